// ===== src/tql_pkg.sv =====
package tql_pkg;

  localparam int ERR_W      = 16;
  localparam int MAG_W      = 17;
  localparam int ACT_W      = 2;
  localparam int GAIN_W     = 11;
  localparam int RWD_W      = 8;
  localparam int OUT_Q_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIM_W      = 15;
  localparam int STEP_W     = 8;
  localparam int FRAC_W     = 16;
  localparam int ROW_N      = 3;
  localparam int TABLE_N    = 9;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [1:0] band_t;
  localparam band_t BAND_LOW  = 2'd0;
  localparam band_t BAND_MID  = 2'd1;
  localparam band_t BAND_HIGH = 2'd2;

  typedef logic [ACT_W-1:0] action_t;
  localparam action_t ACT_SLOW = 2'd0;
  localparam action_t ACT_NORM = 2'd1;
  localparam action_t ACT_FAST = 2'd2;
  localparam action_t ACT_NONE = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_SLOW = 11'd973;
  localparam logic [GAIN_W-1:0] GAIN_NORM = 11'd1024;
  localparam logic [GAIN_W-1:0] GAIN_FAST = 11'd1536;

  localparam logic signed [RWD_W-1:0] RWD_CLOSER  = 8'sd10;
  localparam logic signed [RWD_W-1:0] RWD_IN_BAND = 8'sd100;
  localparam logic signed [RWD_W-1:0] RWD_PENALTY = 8'sd50;

  localparam logic [CFG_DATA_W-1:0] LEARN_RATE_RST  = 16'd52429;
  localparam logic [CFG_DATA_W-1:0] DISCOUNT_RST    = 16'd62259;
  localparam logic [LIM_W-1:0]      BAND_LIMIT_RST  = 15'd410;
  localparam logic [LIM_W-1:0]      LARGE_LIMIT_RST = 15'd2048;
  localparam logic [STEP_W-1:0]     STEPS_RST       = 8'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEARN_RATE  = 3'd0,
    REG_DISCOUNT    = 3'd1,
    REG_BAND_LIMIT  = 3'd2,
    REG_LARGE_LIMIT = 3'd3,
    REG_STEPS       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] learn_rate;
    logic [CFG_DATA_W-1:0] discount;
    logic [LIM_W-1:0]      band_limit;
    logic [LIM_W-1:0]      large_limit;
    logic [STEP_W-1:0]     steps;
  } cfg_t;

  // classified sample as handed from front to back
  typedef struct packed {
    logic             start;
    logic             explore;
    action_t          rand_act;
    band_t            band;
    logic [MAG_W-1:0] mag;
    logic             in_band;
    logic             over_large;
  } item_t;

  typedef struct packed {
    action_t                   action;
    logic [GAIN_W-1:0]         gain;
    logic signed [RWD_W-1:0]   reward;
    logic [OUT_Q_W-1:0]        new_q;
    logic                      did_update;
    logic                      episode_done;
  } result_t;

  function automatic logic [GAIN_W-1:0] gain_of(input action_t a);
    logic [GAIN_W-1:0] g;
    case (a)
      ACT_SLOW: g = GAIN_SLOW;
      ACT_NORM: g = GAIN_NORM;
      default:  g = GAIN_FAST;
    endcase
    return g;
  endfunction

endpackage

// ===== src/tql_front.sv =====
module tql_front import tql_pkg::*; (
  input  logic signed [ERR_W-1:0] error_sample,
  input  logic                    episode_start,
  input  logic                    explore,
  input  action_t                 random_action,
  input  cfg_t                    cfg,
  output item_t                   item
);

  logic signed [MAG_W-1:0] e_ext;
  logic signed [MAG_W-1:0] lim;
  logic [MAG_W-1:0]        mag;

  assign e_ext = MAG_W'(error_sample);
  assign lim   = $signed({2'b00, cfg.band_limit});
  assign mag   = (e_ext < 0) ? MAG_W'(-e_ext) : MAG_W'(e_ext);

  always_comb begin
    item.start      = episode_start;
    item.explore    = explore;
    item.rand_act   = (random_action == ACT_NONE) ? ACT_FAST : random_action;
    item.mag        = mag;
    item.in_band    = mag < {2'b00, cfg.band_limit};
    item.over_large = mag > {2'b00, cfg.large_limit};
    if (e_ext < -lim) begin
      item.band = BAND_LOW;
    end else if (e_ext <= lim) begin
      item.band = BAND_MID;
    end else begin
      item.band = BAND_HIGH;
    end
  end

endmodule

// ===== src/tql_fifo.sv =====
module tql_fifo import tql_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  valid
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign valid   = count_r != '0;
  assign rd_item = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= wr_item;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/tql_back.sv =====
module tql_back import tql_pkg::*; #(
  parameter int Q_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output result_t res,
  output logic    res_valid,
  input  logic    res_pop
);

  localparam int QW   = Q_WIDTH;
  localparam int TW   = QW + 4;
  localparam int PRW  = TW + CFG_DATA_W + 1;
  localparam int EXTW = (QW > OUT_Q_W) ? QW : OUT_Q_W;
  localparam int IDXW = $clog2(TABLE_N);

  localparam logic signed [TW-1:0] QMAX = {{(TW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam logic signed [TW-1:0] QMIN = ~QMAX;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) <<< (FRAC_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CUR, S_NXT, S_MULG, S_DIFF, S_MULA, S_WRITE
  } state_t;

  state_t                  state_r;
  logic signed [QW-1:0]    q_r [TABLE_N];
  item_t                   item_r;
  logic                    active_r;
  band_t                   band_r;
  logic [MAG_W-1:0]        prev_mag_r;
  logic [STEP_W-1:0]       step_r;
  action_t                 action_r;
  logic signed [RWD_W-1:0] reward_r;
  logic signed [QW-1:0]    qold_r;
  logic signed [QW-1:0]    maxq_r;
  logic signed [PRW-1:0]   prod_r;
  logic signed [TW-1:0]    diff_r;
  result_t                 res_r;
  logic                    res_valid_r;

  band_t                   row_sel;
  logic signed [QW-1:0]    row_q0, row_q1, row_q2;
  action_t                 best;
  logic signed [QW-1:0]    row_max;
  action_t                 action_sel;
  logic signed [QW-1:0]    qsel;
  logic signed [RWD_W-1:0] reward_c;
  logic signed [PRW-1:0]   rnd_full;
  logic signed [TW-1:0]    rnd_t;
  logic signed [TW-1:0]    target;
  logic signed [TW-1:0]    sum;
  logic signed [TW-1:0]    sat;
  logic signed [QW-1:0]    qn;
  logic signed [EXTW-1:0]  qn_ext;
  logic [STEP_W-1:0]       step_nxt;
  logic [STEP_W-1:0]       limit;
  logic                    done;
  logic [IDXW-1:0]         wr_idx;
  logic                    res_set;
  logic                    res_valid_nxt;

  // one row of the table per cycle: current band, then next band
  assign row_sel = (state_r == S_CUR) ? band_r : item_r.band;

  always_comb begin
    case (row_sel)
      BAND_LOW: begin
        row_q0 = q_r[0]; row_q1 = q_r[1]; row_q2 = q_r[2];
      end
      BAND_MID: begin
        row_q0 = q_r[3]; row_q1 = q_r[4]; row_q2 = q_r[5];
      end
      default: begin
        row_q0 = q_r[6]; row_q1 = q_r[7]; row_q2 = q_r[8];
      end
    endcase
  end

  // greedy pick, ties to lower action
  always_comb begin
    best    = ACT_SLOW;
    row_max = row_q0;
    if (row_q1 > row_max) begin
      best    = ACT_NORM;
      row_max = row_q1;
    end
    if (row_q2 > row_max) begin
      best    = ACT_FAST;
      row_max = row_q2;
    end
  end

  assign action_sel = item_r.explore ? item_r.rand_act : best;

  always_comb begin
    case (action_sel)
      ACT_SLOW: qsel = row_q0;
      ACT_NORM: qsel = row_q1;
      default:  qsel = row_q2;
    endcase
  end

  always_comb begin
    reward_c = '0;
    if (item_r.mag < prev_mag_r) reward_c = reward_c + RWD_CLOSER;
    if (item_r.in_band)          reward_c = reward_c + RWD_IN_BAND;
    if (item_r.over_large)       reward_c = reward_c - RWD_PENALTY;
  end

  // round to nearest, ties up, of a product by a Q0.16 factor
  assign rnd_full = (prod_r + HALF) >>> FRAC_W;
  assign rnd_t    = TW'(rnd_full);
  assign target   = (TW'(reward_r) <<< FRAC_W) + rnd_t;
  assign sum      = TW'(qold_r) + rnd_t;
  assign sat      = (sum > QMAX) ? QMAX : ((sum < QMIN) ? QMIN : sum);
  assign qn       = QW'(sat);
  assign qn_ext   = EXTW'(qn);

  assign step_nxt = step_r + 1'b1;
  assign limit    = (cfg.steps == '0) ? STEP_W'(1) : cfg.steps;
  assign done     = item_r.in_band || (step_nxt >= limit);
  assign wr_idx   = IDXW'({band_r, 1'b0}) + IDXW'(band_r) + IDXW'(action_r);

  assign q_pop     = (state_r == S_IDLE) && q_valid && (!res_valid_r || res_pop);
  assign res       = res_r;
  assign res_valid = res_valid_r;

  // a new word lands in the result register, or the waiting one is taken
  assign res_set       = (q_pop && (q_item.start || !active_r)) || (state_r == S_WRITE);
  assign res_valid_nxt = res_set || (res_valid_r && !res_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      band_r      <= BAND_MID;
      prev_mag_r  <= '0;
      step_r      <= '0;
      res_valid_r <= 1'b0;
      for (int i = 0; i < TABLE_N; i++) begin
        q_r[i] <= '0;
      end
    end else begin
      res_valid_r <= res_valid_nxt;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            item_r <= q_item;
            if (q_item.start) begin
              band_r      <= q_item.band;
              prev_mag_r  <= '0;
              step_r      <= '0;
              active_r    <= 1'b1;
              res_r       <= '0;
            end else if (!active_r) begin
              res_r       <= '0;
            end else begin
              state_r <= S_CUR;
            end
          end
        end
        S_CUR: begin
          action_r <= action_sel;
          qold_r   <= qsel;
          reward_r <= reward_c;
          state_r  <= S_NXT;
        end
        S_NXT: begin
          maxq_r  <= row_max;
          state_r <= S_MULG;
        end
        S_MULG: begin
          prod_r  <= PRW'(maxq_r) * PRW'($signed({1'b0, cfg.discount}));
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          diff_r  <= target - TW'(qold_r);
          state_r <= S_MULA;
        end
        S_MULA: begin
          prod_r  <= PRW'(diff_r) * PRW'($signed({1'b0, cfg.learn_rate}));
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          q_r[wr_idx]        <= qn;
          step_r             <= step_nxt;
          prev_mag_r         <= item_r.mag;
          band_r             <= item_r.band;
          if (done) active_r <= 1'b0;
          res_r.action       <= action_r;
          res_r.gain         <= gain_of(action_r);
          res_r.reward       <= reward_r;
          res_r.new_q        <= qn_ext[OUT_Q_W-1:0];
          res_r.did_update   <= 1'b1;
          res_r.episode_done <= done;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_in_episode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> active_r)
    else $error("update sequence running outside an episode");

  a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> res_valid_r)
    else $error("table write did not produce a result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_pop) |=> (res_valid_r && $stable(res_r)))
    else $error("pending result lost or changed before it was taken");

endmodule

// ===== src/tabular_q_learning_update.sv =====
// tabular q-learning update for a three-band crosstrack controller. samples go in through a
// two-word input queue; the front classifies each sample (band, magnitude, in-band and
// penalty flags) as it is pushed. the back works one word at a time: an episode start or a
// sample outside an episode is written to the result register, as it is taken, with all
// result fields zero; an update sample runs six steps once it is taken (current row read,
// next row read, gamma multiply, target subtract, alpha multiply, saturate and write back).
// the back takes no new word until that sequence is back in idle, the two row reads sharing
// the one row select of the table. the back only takes the next word once the
// result register is empty or being popped, so a waiting result holds the back while the
// input queue keeps taking samples until it fills. config writes are taken at any time but
// must only come while the block is idle; cfg_ready is always high.
module tabular_q_learning_update import tql_pkg::*; #(
  parameter int Q_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // sample input queue side
  input  logic                    push,
  output logic                    full,
  input  logic signed [ERR_W-1:0] in_error_sample,
  input  logic                    in_episode_start,
  input  logic                    in_explore,
  input  logic [ACT_W-1:0]        in_random_action,
  // result register side
  output logic                    empty,
  input  logic                    pop,
  output logic [ACT_W-1:0]        out_chosen_action,
  output logic [GAIN_W-1:0]       out_gain_value,
  output logic signed [RWD_W-1:0] out_step_reward,
  output logic signed [OUT_Q_W-1:0] out_new_q_value,
  output logic                    out_did_update,
  output logic                    out_episode_done,
  // config write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t    cfg_r;
  item_t   front_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t res;
  logic    res_valid;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learn_rate  <= LEARN_RATE_RST;
      cfg_r.discount    <= DISCOUNT_RST;
      cfg_r.band_limit  <= BAND_LIMIT_RST;
      cfg_r.large_limit <= LARGE_LIMIT_RST;
      cfg_r.steps       <= STEPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEARN_RATE:  cfg_r.learn_rate  <= cfg_data;
        REG_DISCOUNT:    cfg_r.discount    <= cfg_data;
        REG_BAND_LIMIT:  cfg_r.band_limit  <= cfg_data[LIM_W-1:0];
        REG_LARGE_LIMIT: cfg_r.large_limit <= cfg_data[LIM_W-1:0];
        REG_STEPS:       cfg_r.steps       <= cfg_data[STEP_W-1:0];
        default:         cfg_r             <= cfg_r;   // unused index, dropped
      endcase
    end
  end

  // front: classify the incoming sample
  tql_front u_front (
    .error_sample  (in_error_sample),
    .episode_start (in_episode_start),
    .explore       (in_explore),
    .random_action (in_random_action),
    .cfg           (cfg_r),
    .item          (front_item)
  );

  // short queue between front and back
  tql_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (front_item),
    .full    (full),
    .pop     (q_pop),
    .rd_item (q_item),
    .valid   (q_valid)
  );

  // back: table update sequencer and result register
  tql_back #(
    .Q_WIDTH (Q_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  // result word on the output ports
  assign empty             = !res_valid;
  assign out_chosen_action = res.action;
  assign out_gain_value    = res.gain;
  assign out_step_reward   = res.reward;
  assign out_new_q_value   = res.new_q;
  assign out_did_update    = res.did_update;
  assign out_episode_done  = res.episode_done;

endmodule
